/* sv/particle_swarm_update_defines.svh */
// Assertion macros used by the particle swarm update property module.
`ifndef PARTICLE_SWARM_UPDATE_DEFINES_SVH
`define PARTICLE_SWARM_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: property failed");

`endif

/* sv/psu_pkg.sv */
// Shared types, constants and codes for the particle swarm update block.
package psu_pkg;

    localparam int NUM_PARTICLES = 64;
    localparam int ADDR_W        = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
    localparam int IDX_W         = 6;
    localparam int POS_W         = 32;
    localparam int VAL_W         = 48;
    localparam int WT_W          = 16;
    localparam int RND_W         = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [WT_W-1:0]  INERTIA_RST   = 16'd11469;
    localparam logic [WT_W-1:0]  COGNITIVE_RST = 16'd24576;
    localparam logic [WT_W-1:0]  SOCIAL_RST    = 16'd24576;
    localparam logic [VAL_W-1:0] VAL_MAX       = {VAL_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INERTIA   = 2'd0,
        REG_COGNITIVE = 2'd1,
        REG_SOCIAL    = 2'd2
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_UPDATE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_POS,
        S_OBJ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic mul1;
        logic mul2;
        logic sum;
        logic pos;
        logic obj;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] vel;
        logic [POS_W-1:0] pbp;
        logic [VAL_W-1:0] pbv;
    } t_row;

endpackage

/* sv/psu_ctrl.sv */
// Sequencer for the particle swarm update: steps one request through the datapath.
module psu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  psu_pkg::t_sts i_sts,
    output psu_pkg::t_cmd o_cmd,
    output logic          o_stall
);
    import psu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM:  n_state = S_POS;
            S_POS:  n_state = S_OBJ;
            S_OBJ:  n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:  o_cmd.load_in = i_valid;
            S_MUL1:  o_cmd.mul1    = 1'b1;
            S_MUL2:  o_cmd.mul2    = 1'b1;
            S_SUM:   o_cmd.sum     = 1'b1;
            S_POS:   o_cmd.pos     = 1'b1;
            S_OBJ:   o_cmd.obj     = 1'b1;
            S_DONE:  o_cmd.commit  = i_sts.out_free;
            default: o_cmd         = '0;
        endcase
    end

endmodule

/* sv/psu_datapath.sv */
// Datapath: particle table, weight registers, arithmetic stages, bests and result register.
module psu_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  psu_pkg::t_cmd                       i_cmd,
    output psu_pkg::t_sts                       o_sts,
    input  logic                                i_cfg_valid,
    input  logic [psu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psu_pkg::WT_W-1:0]            i_cfg_data,
    input  logic                                i_operation,
    input  logic [psu_pkg::IDX_W-1:0]           i_particle_index,
    input  logic signed [psu_pkg::POS_W-1:0]    i_load_position,
    input  logic signed [psu_pkg::POS_W-1:0]    i_load_velocity,
    input  logic [psu_pkg::RND_W-1:0]           i_random_cognitive,
    input  logic [psu_pkg::RND_W-1:0]           i_random_social,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic signed [psu_pkg::POS_W-1:0]    o_new_position,
    output logic [psu_pkg::VAL_W-1:0]           o_new_value,
    output logic signed [psu_pkg::POS_W-1:0]    o_global_best_position,
    output logic [psu_pkg::VAL_W-1:0]           o_global_best_value,
    output logic                                o_global_improved,
    output logic                                o_saturated
);
    import psu_pkg::*;

    localparam logic signed [37:0] SUM_MAX = 38'sd2147483647;
    localparam logic signed [37:0] SUM_MIN = -38'sd2147483648;

    // weights
    logic [WT_W-1:0] r_inertia;
    logic [WT_W-1:0] r_cognitive;
    logic [WT_W-1:0] r_social;

    // particle table
    t_row r_mem [NUM_PARTICLES];
    t_row r_rd;

    // captured request
    logic               r_op;
    logic [IDX_W-1:0]   r_idx;
    logic [POS_W-1:0]   r_lpos;
    logic [POS_W-1:0]   r_lvel;
    logic [RND_W-1:0]   r_rc;
    logic [RND_W-1:0]   r_rs;

    // global best
    logic [POS_W-1:0]   r_gbp;
    logic [VAL_W-1:0]   r_gbv;

    // pipeline registers
    logic signed [48:0] r_wv;
    logic [WT_W-1:0]    r_cr;
    logic [WT_W-1:0]    r_sr;
    logic signed [32:0] r_dp;
    logic signed [32:0] r_dg;
    logic signed [34:0] r_wvs;
    logic signed [49:0] r_tp;
    logic signed [49:0] r_tg;
    logic [POS_W-1:0]   r_nv;
    logic               r_sat_v;
    logic [POS_W-1:0]   r_pos;
    logic               r_sat;
    logic [VAL_W-1:0]   r_val;

    // result register
    logic               r_out_valid;

    logic [31:0]        prod_c;
    logic [31:0]        prod_s;
    logic signed [37:0] sum_c;
    logic [POS_W-1:0]   nv_c;
    logic               sat_v_c;
    logic signed [32:0] psum_c;
    logic [POS_W-1:0]   pos_c;
    logic               sat_p_c;
    logic [POS_W-1:0]   mag_c;
    logic [63:0]        sq_c;
    logic               idx_ok;
    logic               pb_better;
    logic               gb_better;
    t_row               wr_row;

    assign prod_c = r_cognitive * r_rc;
    assign prod_s = r_social * r_rs;

    assign sum_c = {{3{r_wvs[34]}}, r_wvs}
                 + {{2{r_tp[49]}}, r_tp[49:14]}
                 + {{2{r_tg[49]}}, r_tg[49:14]};

    always_comb begin
        nv_c    = sum_c[POS_W-1:0];
        sat_v_c = 1'b0;
        if (sum_c > SUM_MAX) begin
            nv_c    = 32'h7FFF_FFFF;
            sat_v_c = 1'b1;
        end else if (sum_c < SUM_MIN) begin
            nv_c    = 32'h8000_0000;
            sat_v_c = 1'b1;
        end
    end

    assign psum_c = $signed({r_rd.pos[POS_W-1], r_rd.pos}) + $signed({r_nv[POS_W-1], r_nv});

    always_comb begin
        pos_c   = psum_c[POS_W-1:0];
        sat_p_c = 1'b0;
        if (psum_c[32] != psum_c[31]) begin
            pos_c   = psum_c[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            sat_p_c = 1'b1;
        end
    end

    assign mag_c = r_pos[POS_W-1] ? (~r_pos + 32'd1) : r_pos;
    assign sq_c  = mag_c * mag_c;

    assign idx_ok    = (32'(r_idx) < 32'(NUM_PARTICLES));
    assign pb_better = (r_val < r_rd.pbv);
    assign gb_better = idx_ok && (r_val < r_gbv);

    always_comb begin
        wr_row.pos = r_pos;
        if (r_op == OP_LOAD) begin
            wr_row.vel = r_lvel;
            wr_row.pbp = r_pos;
            wr_row.pbv = r_val;
        end else begin
            wr_row.vel = r_nv;
            wr_row.pbp = pb_better ? r_pos : r_rd.pbp;
            wr_row.pbv = pb_better ? r_val : r_rd.pbv;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_valid        = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inertia   <= INERTIA_RST;
            r_cognitive <= COGNITIVE_RST;
            r_social    <= SOCIAL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_INERTIA:   r_inertia   <= i_cfg_data;
                REG_COGNITIVE: r_cognitive <= i_cfg_data;
                REG_SOCIAL:    r_social    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_rd <= r_mem[ADDR_W'(i_particle_index)];
        end
        if (i_cmd.commit && idx_ok) begin
            r_mem[ADDR_W'(r_idx)] <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_operation;
            r_idx  <= i_particle_index;
            r_lpos <= i_load_position;
            r_lvel <= i_load_velocity;
            r_rc   <= i_random_cognitive;
            r_rs   <= i_random_social;
        end
        if (i_cmd.mul1) begin
            r_wv <= $signed({1'b0, r_inertia}) * $signed(r_rd.vel);
            r_cr <= prod_c[31:16];
            r_sr <= prod_s[31:16];
            r_dp <= $signed({r_rd.pbp[POS_W-1], r_rd.pbp}) - $signed({r_rd.pos[POS_W-1], r_rd.pos});
            r_dg <= $signed({r_gbp[POS_W-1], r_gbp}) - $signed({r_rd.pos[POS_W-1], r_rd.pos});
        end
        if (i_cmd.mul2) begin
            r_wvs <= r_wv[48:14];
            r_tp  <= $signed({1'b0, r_cr}) * r_dp;
            r_tg  <= $signed({1'b0, r_sr}) * r_dg;
        end
        if (i_cmd.sum) begin
            r_nv    <= nv_c;
            r_sat_v <= sat_v_c;
        end
        if (i_cmd.pos) begin
            if (r_op == OP_LOAD) begin
                r_pos <= r_lpos;
                r_sat <= 1'b0;
            end else begin
                r_pos <= pos_c;
                r_sat <= r_sat_v | sat_p_c;
            end
        end
        if (i_cmd.obj) begin
            r_val <= sq_c[63:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gbp <= '0;
            r_gbv <= VAL_MAX;
        end else if (i_cmd.commit && gb_better) begin
            r_gbp <= r_pos;
            r_gbv <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_new_position         <= idx_ok ? r_pos : '0;
            o_new_value            <= idx_ok ? r_val : '0;
            o_global_best_position <= gb_better ? r_pos : r_gbp;
            o_global_best_value    <= gb_better ? r_val : r_gbv;
            o_global_improved      <= gb_better;
            o_saturated            <= idx_ok && r_sat;
        end
    end

endmodule

/* sv/particle_swarm_update.sv */
// Top level of the one-dimensional particle swarm update block.
// Each request (load or update of one particle) reaches the result register in seven
// steps one after the other: the table read at the accepting edge, the weight and random
// products, the difference products, the velocity sum and clip, the position clip, the x
// squared product, and the table write with the best refresh. The next request is taken
// in the cycle after that write once the result register is free, so the block takes no
// new request before it is through with the last one; a stalled result holds the write
// step until it is taken. This one-at-a-time flow is set by the multiplier chain and the
// read-modify-write of the single-port particle table. The particle table has no reset
// and needs no clearing pass; an update of a particle that was never loaded gives
// undefined results. Weight registers may be written at any time the block is idle and
// are always ready.
module particle_swarm_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_operation,
    input  logic [psu_pkg::IDX_W-1:0]           i_particle_index,
    input  logic signed [psu_pkg::POS_W-1:0]    i_load_position,
    input  logic signed [psu_pkg::POS_W-1:0]    i_load_velocity,
    input  logic [psu_pkg::RND_W-1:0]           i_random_cognitive,
    input  logic [psu_pkg::RND_W-1:0]           i_random_social,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [psu_pkg::POS_W-1:0]    o_new_position,
    output logic [psu_pkg::VAL_W-1:0]           o_new_value,
    output logic signed [psu_pkg::POS_W-1:0]    o_global_best_position,
    output logic [psu_pkg::VAL_W-1:0]           o_global_best_value,
    output logic                                o_global_improved,
    output logic                                o_saturated,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psu_pkg::WT_W-1:0]            i_cfg_data
);
    import psu_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    psu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    psu_datapath u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_sts                  (sts),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_operation            (i_operation),
        .i_particle_index       (i_particle_index),
        .i_load_position        (i_load_position),
        .i_load_velocity        (i_load_velocity),
        .i_random_cognitive     (i_random_cognitive),
        .i_random_social        (i_random_social),
        .i_stall                (i_stall),
        .o_valid                (o_valid),
        .o_new_position         (o_new_position),
        .o_new_value            (o_new_value),
        .o_global_best_position (o_global_best_position),
        .o_global_best_value    (o_global_best_value),
        .o_global_improved      (o_global_improved),
        .o_saturated            (o_saturated)
    );

endmodule

/* sv/psu_props.sv */
// Port-level properties of the particle swarm update block, bound to its top level.
`include "particle_swarm_update_defines.svh"

module psu_props (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [psu_pkg::POS_W-1:0]        o_new_position,
    input logic [psu_pkg::VAL_W-1:0]        o_new_value,
    input logic [psu_pkg::POS_W-1:0]        o_global_best_position,
    input logic [psu_pkg::VAL_W-1:0]        o_global_best_value,
    input logic                             o_global_improved
);

    `PSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_new_position) && $stable(o_global_best_value))
    `PSU_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `PSU_ASSERT_NOW(a_improved_is_best, i_clk, i_rst_n, o_valid && o_global_improved, (o_global_best_value == o_new_value) && (o_global_best_position == o_new_position))
    `PSU_ASSERT_NOW(a_value_range, i_clk, i_rst_n, o_valid, o_new_value[47] == 1'b0)

endmodule

bind particle_swarm_update psu_props u_psu_props (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_valid                (i_valid),
    .o_stall                (o_stall),
    .o_valid                (o_valid),
    .i_stall                (i_stall),
    .o_new_position         (o_new_position),
    .o_new_value            (o_new_value),
    .o_global_best_position (o_global_best_position),
    .o_global_best_value    (o_global_best_value),
    .o_global_improved      (o_global_improved)
);

/* tb/sv/psu_checker.sv */
`timescale 1ns / 1ps
// Result checker for the particle swarm update block: tracks the swarm and compares each result.
module psu_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_stall,
    input  logic                             i_operation,
    input  logic [psu_pkg::IDX_W-1:0]        i_particle_index,
    input  logic signed [psu_pkg::POS_W-1:0] i_load_position,
    input  logic signed [psu_pkg::POS_W-1:0] i_load_velocity,
    input  logic [psu_pkg::RND_W-1:0]        i_random_cognitive,
    input  logic [psu_pkg::RND_W-1:0]        i_random_social,
    input  logic                             i_res_valid,
    input  logic                             i_res_stall,
    input  logic signed [psu_pkg::POS_W-1:0] i_new_position,
    input  logic [psu_pkg::VAL_W-1:0]        i_new_value,
    input  logic signed [psu_pkg::POS_W-1:0] i_global_best_position,
    input  logic [psu_pkg::VAL_W-1:0]        i_global_best_value,
    input  logic                             i_global_improved,
    input  logic                             i_saturated,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [psu_pkg::WT_W-1:0]         i_cfg_data,
    output int                               o_error_count,
    output int                               o_pending
);
    import psu_pkg::*;

    localparam int     MAX_REPORTS = 10;
    localparam longint POS_MAX     = 64'sd2147483647;
    localparam longint POS_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [VAL_W-1:0]        value;
        logic signed [POS_W-1:0] best_position;
        logic [VAL_W-1:0]        best_value;
        logic                    improved;
        logic                    clipped;
    } t_swarm_result;

    logic signed [POS_W-1:0] position_mem [NUM_PARTICLES];
    logic signed [POS_W-1:0] velocity_mem [NUM_PARTICLES];
    logic signed [POS_W-1:0] own_best_pos [NUM_PARTICLES];
    logic [VAL_W-1:0]        own_best_val [NUM_PARTICLES];
    logic signed [POS_W-1:0] swarm_best_pos;
    logic [VAL_W-1:0]        swarm_best_val;
    logic [WT_W-1:0]         inertia_w;
    logic [WT_W-1:0]         cognitive_w;
    logic [WT_W-1:0]         social_w;
    t_swarm_result           expected_results [$];

    function automatic logic [VAL_W-1:0] square_q16(logic signed [POS_W-1:0] x);
        longint          wide;
        longint unsigned mag;
        wide = x;
        mag  = (wide < 0) ? -wide : wide;
        return VAL_W'((mag * mag) >> 16);
    endfunction

    function automatic logic signed [POS_W-1:0] clip_q16(longint x, inout bit hit);
        if (x > POS_MAX) begin
            hit = 1'b1;
            return POS_W'(POS_MAX);
        end
        if (x < POS_MIN) begin
            hit = 1'b1;
            return POS_W'(POS_MIN);
        end
        return POS_W'(x);
    endfunction

    task automatic predict_request();
        t_swarm_result           res;
        longint                  x;
        longint                  v;
        longint                  wl;
        longint                  cl;
        longint                  sl;
        longint                  r1l;
        longint                  r2l;
        longint                  acc;
        logic signed [POS_W-1:0] nv;
        bit                      hit;
        int                      idx;
        idx          = i_particle_index;
        hit          = 1'b0;
        res.improved = 1'b0;
        if (t_op'(i_operation) == OP_LOAD) begin
            res.position      = i_load_position;
            res.value         = square_q16(i_load_position);
            position_mem[idx] = i_load_position;
            velocity_mem[idx] = i_load_velocity;
            own_best_pos[idx] = i_load_position;
            own_best_val[idx] = res.value;
        end else begin
            x   = position_mem[idx];
            v   = velocity_mem[idx];
            wl  = inertia_w;
            cl  = cognitive_w;
            sl  = social_w;
            r1l = i_random_cognitive;
            r2l = i_random_social;
            cl  = (cl * r1l) >>> 16;
            sl  = (sl * r2l) >>> 16;
            acc = ((wl * v) >>> 14)
                + ((cl * (longint'(own_best_pos[idx]) - x)) >>> 14)
                + ((sl * (longint'(swarm_best_pos) - x)) >>> 14);
            nv                = clip_q16(acc, hit);
            res.position      = clip_q16(x + longint'(nv), hit);
            res.value         = square_q16(res.position);
            velocity_mem[idx] = nv;
            position_mem[idx] = res.position;
            if (res.value < own_best_val[idx]) begin
                own_best_pos[idx] = res.position;
                own_best_val[idx] = res.value;
            end
        end
        if (res.value < swarm_best_val) begin
            swarm_best_pos = res.position;
            swarm_best_val = res.value;
            res.improved   = 1'b1;
        end
        res.best_position = swarm_best_pos;
        res.best_value    = swarm_best_val;
        res.clipped       = hit;
        expected_results.push_back(res);
    endtask

    task automatic check_result();
        t_swarm_result want;
        t_swarm_result got;
        got = {i_new_position, i_new_value, i_global_best_position, i_global_best_value,
               i_global_improved, i_saturated};
        if (expected_results.size() == 0) begin
            o_error_count++;
            if (o_error_count <= MAX_REPORTS) begin
                $display("psu_checker: unexpected result pos %h val %h", got.position,
                         got.value);
            end
        end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
                o_error_count++;
                if (o_error_count <= MAX_REPORTS) begin
                    $display("psu_checker: mismatch at %0t (expected / actual)", $time);
                    $display("  pos %h / %h  val %h / %h", want.position, got.position,
                             want.value, got.value);
                    $display("  best pos %h / %h  best val %h / %h", want.best_position,
                             got.best_position, want.best_value, got.best_value);
                    $display("  improved %b / %b  saturated %b / %b", want.improved,
                             got.improved, want.clipped, got.clipped);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            inertia_w      = INERTIA_RST;
            cognitive_w    = COGNITIVE_RST;
            social_w       = SOCIAL_RST;
            swarm_best_pos = '0;
            swarm_best_val = VAL_MAX;
            expected_results.delete();
            o_error_count  = 0;
            o_pending      = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_INERTIA:   inertia_w   = i_cfg_data;
                    REG_COGNITIVE: cognitive_w = i_cfg_data;
                    REG_SOCIAL:    social_w    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall) begin
                predict_request();
            end
            if (i_res_valid && !i_res_stall) begin
                check_result();
            end
            o_pending = expected_results.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the particle swarm update block: clock, reset, stimulus and verdict.
module tb_top;
    import psu_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;
    localparam int                   PHASES       = 5;
    localparam int                   PHASE_ITEMS  = 350;
    localparam int                   DRAIN_CYCLES = 16;
    localparam logic signed [31:0]   POS_TOP      = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]   POS_BOTTOM   = 32'sh8000_0000;
    localparam logic signed [31:0]   Q_1000       = 32'sh03E8_0000;
    localparam logic signed [31:0]   Q_HALF       = 32'sh0000_8000;
    localparam logic [RND_W-1:0]     RND_ONE      = 16'hFFFF;
    localparam logic [RND_W-1:0]     RND_HALF     = 16'h8000;
    localparam logic [WT_W-1:0]      WT_MAX       = 16'hFFFF;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_operation;
    logic [IDX_W-1:0]         i_particle_index;
    logic signed [POS_W-1:0]  i_load_position;
    logic signed [POS_W-1:0]  i_load_velocity;
    logic [RND_W-1:0]         i_random_cognitive;
    logic [RND_W-1:0]         i_random_social;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [POS_W-1:0]  o_new_position;
    logic [VAL_W-1:0]         o_new_value;
    logic signed [POS_W-1:0]  o_global_best_position;
    logic [VAL_W-1:0]         o_global_best_value;
    logic                     o_global_improved;
    logic                     o_saturated;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [WT_W-1:0]          i_cfg_data;

    int error_count;
    int pending_results;
    int gap_pct;
    int stall_pct;
    bit particle_loaded [NUM_PARTICLES];

    particle_swarm_update dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_operation            (i_operation),
        .i_particle_index       (i_particle_index),
        .i_load_position        (i_load_position),
        .i_load_velocity        (i_load_velocity),
        .i_random_cognitive     (i_random_cognitive),
        .i_random_social        (i_random_social),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_new_position         (o_new_position),
        .o_new_value            (o_new_value),
        .o_global_best_position (o_global_best_position),
        .o_global_best_value    (o_global_best_value),
        .o_global_improved      (o_global_improved),
        .o_saturated            (o_saturated),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    psu_checker u_result_check (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_req_valid            (i_valid),
        .i_req_stall            (o_stall),
        .i_operation            (i_operation),
        .i_particle_index       (i_particle_index),
        .i_load_position        (i_load_position),
        .i_load_velocity        (i_load_velocity),
        .i_random_cognitive     (i_random_cognitive),
        .i_random_social        (i_random_social),
        .i_res_valid            (o_valid),
        .i_res_stall            (i_stall),
        .i_new_position         (o_new_position),
        .i_new_value            (o_new_value),
        .i_global_best_position (o_global_best_position),
        .i_global_best_value    (o_global_best_value),
        .i_global_improved      (o_global_improved),
        .i_saturated            (o_saturated),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .o_error_count          (error_count),
        .o_pending              (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_request(t_op op, logic [IDX_W-1:0] idx, logic signed [31:0] pos,
                                logic signed [31:0] vel, logic [RND_W-1:0] r1,
                                logic [RND_W-1:0] r2);
        while ($urandom_range(0, 99) < gap_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid            <= 1'b1;
        i_operation        <= op;
        i_particle_index   <= idx;
        i_load_position    <= pos;
        i_load_velocity    <= vel;
        i_random_cognitive <= r1;
        i_random_social    <= r2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (op == OP_LOAD) begin
            particle_loaded[idx] = 1'b1;
        end
    endtask

    task automatic random_request();
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        t_op                op;
        idx = IDX_W'($urandom_range(0, NUM_PARTICLES - 1));
        op  = (!particle_loaded[idx] || $urandom_range(0, 99) < 20) ? OP_LOAD : OP_UPDATE;
        if ($urandom_range(0, 9) == 0) begin
            pos = $urandom;
            vel = $urandom;
        end else begin
            pos = $urandom_range(0, 32'h001F_FFFF);
            pos = pos - 32'sh0010_0000;
            vel = $urandom_range(0, 32'h0007_FFFF);
            vel = vel - 32'sh0004_0000;
        end
        send_request(op, idx, pos, vel, RND_W'($urandom_range(0, 65535)),
                     RND_W'($urandom_range(0, 65535)));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic program_weights(logic [WT_W-1:0] w, logic [WT_W-1:0] c,
                                   logic [WT_W-1:0] s);
        write_reg(REG_INERTIA, w);
        write_reg(REG_COGNITIVE, c);
        write_reg(REG_SOCIAL, s);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_stall            = 1'b0;
        i_operation        = OP_LOAD;
        i_particle_index   = '0;
        i_load_position    = '0;
        i_load_velocity    = '0;
        i_random_cognitive = '0;
        i_random_social    = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = REG_INERTIA;
        i_cfg_data         = '0;
        gap_pct            = 0;
        stall_pct          = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_LOAD, 6'd0, POS_TOP, POS_BOTTOM, '0, '0);
        send_request(OP_LOAD, 6'd1, POS_BOTTOM, POS_TOP, RND_ONE, RND_ONE);
        send_request(OP_LOAD, 6'd2, Q_1000, Q_HALF, '0, '0);
        send_request(OP_LOAD, 6'd63, -Q_1000, -Q_HALF, '0, '0);
        send_request(OP_UPDATE, 6'd0, '0, '0, '0, '0);
        send_request(OP_UPDATE, 6'd1, '0, '0, RND_ONE, RND_ONE);
        send_request(OP_UPDATE, 6'd2, '0, '0, RND_ONE, '0);
        send_request(OP_UPDATE, 6'd63, '0, '0, '0, RND_ONE);
        send_request(OP_LOAD, 6'd3, POS_TOP, POS_TOP, '0, '0);
        send_request(OP_UPDATE, 6'd3, '0, '0, RND_HALF, RND_HALF);
        send_request(OP_LOAD, 6'd4, '0, '0, '0, '0);
        send_request(OP_UPDATE, 6'd4, '0, '0, RND_ONE, RND_ONE);
        send_request(OP_UPDATE, 6'd2, '0, '0, RND_HALF, RND_ONE);
        drain();

        write_reg(REG_SPARE, WT_MAX);
        program_weights(WT_MAX, WT_MAX, WT_MAX);
        send_request(OP_UPDATE, 6'd1, '0, '0, RND_ONE, RND_ONE);
        send_request(OP_UPDATE, 6'd0, '0, '0, RND_HALF, RND_ONE);
        send_request(OP_LOAD, 6'd5, POS_BOTTOM, POS_BOTTOM, '0, '0);
        send_request(OP_UPDATE, 6'd5, '0, '0, RND_ONE, RND_ONE);
        send_request(OP_UPDATE, 6'd63, '0, '0, RND_ONE, RND_ONE);
        drain();

        program_weights('0, '0, '0);
        send_request(OP_UPDATE, 6'd2, '0, '0, RND_ONE, RND_ONE);
        send_request(OP_UPDATE, 6'd5, '0, '0, RND_ONE, RND_ONE);
        send_request(OP_LOAD, 6'd6, 32'sd1, -32'sd1, '0, '0);
        send_request(OP_UPDATE, 6'd6, '0, '0, RND_ONE, RND_ONE);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0, 3: program_weights(INERTIA_RST, COGNITIVE_RST, SOCIAL_RST);
                2: program_weights(WT_W'($urandom_range(0, 16383)),
                                   WT_W'($urandom_range(0, 32767)),
                                   WT_W'($urandom_range(0, 32767)));
                default: program_weights(WT_W'($urandom_range(0, 65535)),
                                         WT_W'($urandom_range(0, 65535)),
                                         WT_W'($urandom_range(0, 65535)));
            endcase
            case (p % 4)
                1: begin
                    gap_pct   = 61;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct   = 0;
                    stall_pct = 61;
                end
                3: begin
                    gap_pct   = 17;
                    stall_pct = 17;
                end
                default: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            repeat (PHASE_ITEMS) random_request();
            drain();
        end

        if (error_count == 0 && pending_results == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/psu_pkg.sv
sv/psu_ctrl.sv
sv/psu_datapath.sv
sv/particle_swarm_update.sv
sv/psu_props.sv
tb/sv/psu_checker.sv
tb/sv/tb_top.sv
